// ===== sv/qps_pkg.sv =====
// Shared types and constants for the quantized phase step unit.
package qps_pkg;
	localparam int unsigned DataW = 64;
	localparam int unsigned QuantW = 63;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CfgQuantum = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgGain = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgGradient = 2'd2;
	localparam logic [63:0] GainReset = 64'h0000_0001_0000_0000;
	localparam logic [63:0] GradReset = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MetricGrowth = 64'h0000_0000_0001_0000;

	typedef struct packed {
		logic start_div;
		logic div_step;
		logic round;
		logic mul_step;
		logic finish;
	} qps_cmd_t;

	typedef struct packed {
		logic div_last;
		logic mul_last;
	} qps_sts_t;
endpackage

// ===== sv/qps_if.sv =====
// Valid/ready channel carrying one item.
interface qps_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/qps_ctrl.sv =====
// Controller sequencing divide, round, multiply and commit.
module qps_ctrl import qps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_busy,
	input qps_sts_t sts,
	output qps_cmd_t cmd,
	output logic idle
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_RND = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;
	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		idle = 1'b0;
		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					cmd.start_div = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_RND;
			end
			S_RND: begin
				cmd.round = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE) else $error("finish must return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("item accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one command");
endmodule

// ===== sv/qps_dp.sv =====
// Datapath: restoring divider, tie-to-even rounding, 32x32 multiply sweep, limits.
module qps_dp import qps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input qps_cmd_t cmd,
	output qps_sts_t sts,
	input logic [63:0] target_phase,
	input logic [63:0] tension_headroom,
	input logic [62:0] quantum,
	input logic [63:0] gain,
	input logic [63:0] grad_limit,
	output logic r_accepted,
	output logic [63:0] r_phase,
	output logic [63:0] r_step,
	output logic [63:0] r_total,
	output logic [63:0] r_metric
);
	logic [63:0] phase_q, prev_q, total_q, metric_q;
	logic [63:0] diff_q, tens_q, dphi_q;
	logic [63:0] num_q, quo_q;
	logic [63:0] rem_q;
	logic [5:0] cnt_q;
	logic [1:0] mcnt_q;
	logic [127:0] acc_q;
	logic neg_q;
	logic [63:0] diff_d;

	assign diff_d = target_phase - phase_q;

	// divider on magnitudes
	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	assign rem_sh = {rem_q, num_q[63]};
	assign rem_sub = rem_sh - {2'b0, quantum};

	// rounding
	logic [63:0] rs, qstep, dphi_d;
	logic [62:0] half;
	logic bump;
	always_comb begin
		// signed remainder and one quantum in the direction of the step
		rs = neg_q ? (64'd0 - rem_q) : rem_q;
		qstep = neg_q ? (64'd0 - {1'b0, quantum}) : {1'b0, quantum};
		half = quantum >> 1;
		bump = (rem_q > {1'b0, half}) || ((rem_q == {1'b0, half}) && quo_q[0]);
		// quotient times quantum is the step less its remainder
		dphi_d = (quantum == '0) ? diff_q : diff_q - rs + (bump ? qstep : 64'd0);
	end

	// partial product: a chunk of gain times a chunk of dphi (unsigned)
	logic [31:0] pa, pb;
	logic [63:0] pp;
	assign pa = mcnt_q[1] ? gain[63:32] : gain[31:0];
	assign pb = mcnt_q[0] ? dphi_q[63:32] : dphi_q[31:0];
	assign pp = pa * pb;

	// signed correction and limits
	logic [127:0] prod;
	logic [63:0] step, grad, mag_s, mag_g;
	logic ok;
	always_comb begin
		prod = acc_q;
		if (gain[63]) prod[127:64] = prod[127:64] - dphi_q;
		if (dphi_q[63]) prod[127:64] = prod[127:64] - gain;
		step = prod[95:32];
		grad = step - prev_q;
		mag_s = step[63] ? 64'd0 - step : step;
		mag_g = grad[63] ? 64'd0 - grad : grad;
		ok = !tens_q[63] && (mag_s <= tens_q) && !grad_limit[63] && (mag_g <= grad_limit);
	end

	assign sts.div_last = (cnt_q == 6'd63);
	assign sts.mul_last = (mcnt_q == 2'd3);

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			diff_q <= diff_d;
			tens_q <= tension_headroom;
			neg_q <= diff_d[63];
			num_q <= diff_d[63] ? 64'd0 - diff_d : diff_d;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			mcnt_q <= '0;
			acc_q <= '0;
		end
		if (cmd.div_step) begin
			if (!rem_sub[64]) begin
				rem_q <= rem_sub[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
			num_q <= {num_q[62:0], 1'b0};
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.round) dphi_q <= dphi_d;
		if (cmd.mul_step) begin
			acc_q <= acc_q + (128'(pp) << (7'(mcnt_q[1]) * 7'd32 + 7'(mcnt_q[0]) * 7'd32));
			mcnt_q <= mcnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			prev_q <= '0;
			total_q <= '0;
			metric_q <= '0;
		end else if (cmd.finish) begin
			if (ok) begin
				phase_q <= phase_q + dphi_q;
				prev_q <= step;
				total_q <= total_q + step;
				metric_q <= mag_g;
			end else begin
				metric_q <= metric_q + MetricGrowth;
			end
		end
	end

	assign r_accepted = ok;
	assign r_phase = ok ? phase_q + dphi_q : phase_q;
	assign r_step = step;
	assign r_total = ok ? total_q + step : total_q;
	assign r_metric = ok ? mag_g : metric_q + MetricGrowth;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && !ok |=> $stable(phase_q)) else $error("refused item moved phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.mul_step) else $error("divide and multiply overlap");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && ok |=> prev_q == $past(step)) else $error("previous step not stored");
endmodule

// ===== sv/quantized_phase_step_with_limits_unit.sv =====
// Quantized phase step with tension and gradient limits: one result per item, in the
// order accept, 64 restoring divide steps, round, 4 partial-product multiply steps,
// commit; the bit-serial 64-step divider by the phase quantum sets the pace.
// The commit holds for as long as the previous result still waits in the output register.
// The input channel takes one item at a time and is ready again once the result is
// placed in the output register, while an earlier result may still wait there.
// Users write configuration through a plain port while the block is idle; not enforced.
module quantized_phase_step_with_limits_unit import qps_pkg::*; (
	input logic clk,
	input logic arst_n,
	qps_if.sink in_ch,
	qps_if.source out_ch,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [DataW-1:0] cfg_data
);
	logic [62:0] quantum_q;
	logic [63:0] gain_q, grad_q;
	qps_cmd_t cmd;
	qps_sts_t sts;
	logic idle, in_fire, out_valid_q;
	logic r_acc;
	logic [63:0] r_ph, r_st, r_tot, r_met;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= '0;
			gain_q <= GainReset;
			grad_q <= GradReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgQuantum: quantum_q <= cfg_data[QuantW-1:0];
				CfgGain: gain_q <= cfg_data;
				CfgGradient: grad_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = idle;
	assign in_fire = in_ch.valid && in_ch.ready;

	qps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_valid_q && !out_ch.ready), .sts(sts), .cmd(cmd), .idle(idle)
	);

	qps_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.target_phase(in_ch.data.target_phase),
		.tension_headroom(in_ch.data.tension_headroom),
		.quantum(quantum_q), .gain(gain_q), .grad_limit(grad_q),
		.r_accepted(r_acc), .r_phase(r_ph), .r_step(r_st), .r_total(r_tot), .r_metric(r_met)
	);

	// output register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_ch.data.accepted <= r_acc;
			out_ch.data.new_phase <= r_ph;
			out_ch.data.current_step <= r_st;
			out_ch.data.total_current <= r_tot;
			out_ch.data.convergence_metric <= r_met;
		end
	end
	assign out_ch.valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && !out_ch.ready)) else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !cmd.finish) else $error("accept during commit");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_ch.valid) else $error("result not shown");
endmodule

// ===== sim/qps_tb_pkg.sv =====
// Item types carried on the phase step channels during simulation.
package qps_tb_pkg;
	typedef struct packed {
		logic [63:0] target_phase;
		logic [63:0] tension_headroom;
	} step_req_t;

	typedef struct packed {
		logic accepted;
		logic [63:0] new_phase;
		logic [63:0] current_step;
		logic [63:0] total_current;
		logic [63:0] convergence_metric;
	} step_rsp_t;
endpackage

// ===== sim/qps_checker.sv =====
// Checker: predicts each phase step result and compares it with the block's output.
module qps_checker import qps_pkg::*, qps_tb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [DataW-1:0] cfg_data,
	input logic req_valid,
	input logic req_ready,
	input step_req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input step_rsp_t rsp_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [62:0] quantum;
	logic [63:0] gain, grad_limit;
	logic [63:0] phase, last_step, total, metric;
	step_rsp_t expected_q[$];

	function automatic logic [63:0] round_step(logic [63:0] x, logic [62:0] qnt);
		longint sx, qt, q, r, ar, half;
		if (qnt == '0)
			return x;
		sx = x;
		qt = {1'b0, qnt};
		q = sx / qt;
		r = sx - q * qt;
		ar = (r < 0) ? -r : r;
		half = qt / 2;
		if (ar > half || (ar == half && q[0]))
			q = (sx >= 0) ? q + 1 : q - 1;
		return q * qt;
	endfunction

	function automatic logic [63:0] scale_q32(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
		return p[95:32];
	endfunction

	function automatic bit fits(logic [63:0] x, logic [63:0] lim);
		logic [63:0] mag;
		if (lim[63])
			return 0;
		mag = x[63] ? -x : x;
		return mag <= lim;
	endfunction

	function automatic logic [63:0] abs64(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_rsp_t exp_item;
		logic [63:0] dphi, cur, grad;
		bit ok;
		if (!arst_n) begin
			quantum <= '0;
			gain <= GainReset;
			grad_limit <= GradReset;
			phase <= '0;
			last_step <= '0;
			total <= '0;
			metric <= '0;
			errors <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgQuantum: quantum <= cfg_data[62:0];
					CfgGain: gain <= cfg_data;
					CfgGradient: grad_limit <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item %p", rsp_data);
					errors <= errors + 1;
				end else begin
					exp_item = expected_q.pop_front();
					if (exp_item !== rsp_data) begin
						errors <= errors + 1;
						if (exp_item.accepted !== rsp_data.accepted)
							$error("accepted: expected %0d, got %0d",
								exp_item.accepted, rsp_data.accepted);
						if (exp_item.new_phase !== rsp_data.new_phase)
							$error("new_phase: expected %h, got %h",
								exp_item.new_phase, rsp_data.new_phase);
						if (exp_item.current_step !== rsp_data.current_step)
							$error("current_step: expected %h, got %h",
								exp_item.current_step, rsp_data.current_step);
						if (exp_item.total_current !== rsp_data.total_current)
							$error("total_current: expected %h, got %h",
								exp_item.total_current, rsp_data.total_current);
						if (exp_item.convergence_metric !== rsp_data.convergence_metric)
							$error("convergence_metric: expected %h, got %h",
								exp_item.convergence_metric, rsp_data.convergence_metric);
					end
				end
			end
			if (req_valid && req_ready) begin
				dphi = round_step(req_data.target_phase - phase, quantum);
				cur = scale_q32(gain, dphi);
				grad = cur - last_step;
				ok = fits(cur, req_data.tension_headroom) && fits(grad, grad_limit);
				exp_item.accepted = ok;
				exp_item.current_step = cur;
				if (ok) begin
					exp_item.new_phase = phase + dphi;
					exp_item.total_current = total + cur;
					exp_item.convergence_metric = abs64(grad);
					phase <= phase + dphi;
					last_step <= cur;
					total <= total + cur;
				end else begin
					exp_item.new_phase = phase;
					exp_item.total_current = total;
					exp_item.convergence_metric = metric + MetricGrowth;
				end
				metric <= exp_item.convergence_metric;
				expected_q.push_back(exp_item);
			end
			pending <= expected_q.size();
		end
	end
endmodule

// ===== sim/testbench.sv =====
// Top of the phase step testbench: clock, reset, stimulus and verdict.
module testbench import qps_pkg::*, qps_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;
	localparam int RandomItems = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = CfgQuantum;
	logic [DataW-1:0] cfg_data = '0;
	int errors, pending;
	int quiet_cycles = 0;
	bit calm = 0;            // no idling on either side while set
	logic [63:0] last_target = '0;

	qps_if #(.T(step_req_t)) in_ch ();
	qps_if #(.T(step_rsp_t)) out_ch ();

	quantized_phase_step_with_limits_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	qps_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(in_ch.valid), .req_ready(in_ch.ready),
		.req_data(in_ch.data), .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready),
		.rsp_data(out_ch.data), .errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: stall at random about 12 percent of the time, never while calm.
	always @(posedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 12);
	end

	// Watchdog: give up when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Send one item; idle first at random, hold valid until it is taken.
	task automatic send_item(logic [63:0] target, logic [63:0] tension);
		bit taken;
		while (!calm && $urandom_range(99) < 12) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{target_phase: target, tension_headroom: tension};
		last_target = target;
		// sample ready mid-cycle, where it holds its value for the coming edge
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drain all results, then write the three registers.
	task automatic set_regs(logic [63:0] qnt, logic [63:0] gain, logic [63:0] grad);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CfgQuantum;
		cfg_data <= qnt;
		@(posedge clk);
		cfg_index <= CfgGain;
		cfg_data <= gain;
		@(posedge clk);
		cfg_index <= CfgGradient;
		cfg_data <= grad;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly a target near the last one so that steps pass the limits.
	function automatic logic [63:0] next_target();
		case ($urandom_range(9))
			0: return rand64();
			1: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, $urandom()};
			default: return last_target + {8'h0, $urandom_range(1) ? 24'hFF_FFFF : 24'h0,
				$urandom()} - 64'h0000_0000_8000_0000;
		endcase
	endfunction

	function automatic logic [63:0] next_tension();
		case ($urandom_range(9))
			0: return rand64();
			1: return {32'h0, $urandom()};
			default: return 64'h7FFF_FFFF_FFFF_FFFF - {32'h0, $urandom()};
		endcase
	endfunction

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings (no rounding, unit gain, open gradient limit).
		send_item(64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h0, 64'h0);                       // zero headroom
		send_item(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000); // negative headroom
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(64'h0, 64'h7FFF_FFFF_FFFF_FFFF);

		// Odd quantum with ties, negative gain, zero gradient limit.
		set_regs(64'd3, 64'hFFFF_FFFF_0000_0000, 64'h0);
		send_item(64'd1, 64'h7FFF_FFFF_FFFF_FFFF);     // remainder equals truncated half
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'd0, 64'h7FFF_FFFF_FFFF_FFFF);

		// Even quantum ties both ways, gradient limit wide open.
		set_regs(64'd4, GainReset, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'd2, 64'h7FFF_FFFF_FFFF_FFFF);     // tie, odd quotient
		send_item(64'd8, 64'h7FFF_FFFF_FFFF_FFFF);     // remainder zero, no tie
		send_item(64'hFFFF_FFFF_FFFF_FFF6, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'd13, 64'h7FFF_FFFF_FFFF_FFFF);

		// Largest quantum (top bit of the write dropped), most negative gain and limit.
		set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0000);
		send_item(64'h4000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);

		// Largest gain, fine quantum.
		set_regs(64'h0000_0000_0001_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h0000_0000_0003_8000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_regs(64'h0, GainReset, 64'h7FFF_FFFF_FFFF_FFFF);
				1: set_regs({32'h0, $urandom_range(1, 32'hFFFF)},
					64'h0000_0000_8000_0000, rand64() >> 16);
				2: set_regs({$urandom_range(3), 32'h0} | $urandom_range(7), rand64(),
					rand64());
				3: set_regs(rand64(), {{32{1'b1}}, $urandom()}, 64'h7FFF_FFFF_FFFF_FFFF);
				default: set_regs({48'h0, 16'($urandom())},
					{31'h0, 1'($urandom_range(1)), $urandom()}, rand64() >> 8);
			endcase
			calm = (ph == 2);
			for (int i = 0; i < RandomItems / 5; i++)
				send_item(next_target(), next_tension());
			calm = 0;
		end
		in_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
